[rtl/mfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mfp_pkg;

    localparam logic [7:0] HEAD_MARK   = 8'h68;
    localparam logic [7:0] TAIL_MARK   = 8'h16;
    localparam logic [7:0] DATA_OFFSET = 8'h33;
    localparam int unsigned MIN_FRAME  = 12;
    localparam logic [7:0] MIN_DATA    = 8'd10;

    localparam int unsigned INDEX_W    = 9;
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned ADDR_BYTES = ADDR_W / 8;
    localparam int unsigned READING_W  = 15;

    // byte positions inside the frame
    localparam logic [INDEX_W-1:0] POS_HEAD    = 9'd0;
    localparam logic [INDEX_W-1:0] POS_MIDDLE  = 9'd7;
    localparam logic [INDEX_W-1:0] POS_LENGTH  = 9'd9;
    localparam logic [INDEX_W-1:0] POS_VOLT_LO = 9'd14;
    localparam logic [INDEX_W-1:0] POS_VOLT_HI = 9'd15;
    localparam logic [INDEX_W-1:0] POS_CURR_LO = 9'd16;
    localparam logic [INDEX_W-1:0] POS_CURR_HI = 9'd17;
    localparam logic [INDEX_W-1:0] POS_ENGY_LO = 9'd18;
    localparam logic [INDEX_W-1:0] POS_ENGY_HI = 9'd19;
    localparam logic [INDEX_W-1:0] INDEX_MAX   = {INDEX_W{1'b1}};

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_DELIMITER  = 3'd2,
        ST_LENGTH     = 3'd3,
        ST_CHECKSUM   = 3'd4,
        ST_DATA_SHORT = 3'd5
    } frame_status_t;

    typedef struct packed {
        frame_status_t     status;
        logic [ADDR_W-1:0] address;
        logic [15:0]       voltage_raw;
        logic [15:0]       current_raw;
        logic [15:0]       energy_raw;
    } frame_result_t;

    // nibbles above 9 keep their binary weight
    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        return 8'({4'd0, b[7:4]}) * 8'd10 + 8'({4'd0, b[3:0]});
    endfunction

    function automatic logic [READING_W-1:0] bcd_pair(input logic [15:0] raw);
        return READING_W'(bcd_byte(raw[15:8])) * READING_W'(100)
             + READING_W'(bcd_byte(raw[7:0]));
    endfunction

endpackage

`default_nettype wire

[rtl/mfp_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfp_tracker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [7:0]            frame_byte,
    input  wire logic                  frame_end,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output mfp_pkg::frame_result_t     res_data
);
    import mfp_pkg::*;

    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]         running_sum_reg, running_sum_next;
    logic [7:0]         previous_byte_reg, previous_byte_next;
    logic [ADDR_W-1:0]  address_reg, address_next;
    logic [7:0]         length_reg, length_next;
    logic               start_ok_reg, start_ok_next;
    logic               middle_ok_reg, middle_ok_next;
    logic [15:0]        voltage_raw_reg, voltage_raw_next;
    logic [15:0]        current_raw_reg, current_raw_next;
    logic [15:0]        energy_raw_reg, energy_raw_next;
    logic               res_valid_reg, res_valid_next;
    frame_result_t      res_data_reg, res_data_next;

    logic               accept;
    logic [7:0]         plain;
    logic [INDEX_W:0]   count;
    logic [INDEX_W:0]   expected_count;
    frame_status_t      status;

    assign in_ready  = !res_valid_reg || res_ready;
    assign accept    = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign plain          = frame_byte - DATA_OFFSET;
    assign count          = {1'b0, byte_index_reg} + (INDEX_W+1)'(1);
    assign expected_count = (INDEX_W+1)'(MIN_FRAME) + (INDEX_W+1)'(length_reg);

    always_comb begin
        if (count < (INDEX_W+1)'(MIN_FRAME)) begin
            status = ST_SHORT;
        end else if (!start_ok_reg || !middle_ok_reg || frame_byte != TAIL_MARK) begin
            status = ST_DELIMITER;
        end else if (count != expected_count) begin
            status = ST_LENGTH;
        end else if (running_sum_reg != previous_byte_reg) begin
            status = ST_CHECKSUM;
        end else if (length_reg < MIN_DATA) begin
            status = ST_DATA_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        byte_index_next    = byte_index_reg;
        running_sum_next   = running_sum_reg;
        previous_byte_next = previous_byte_reg;
        address_next       = address_reg;
        length_next        = length_reg;
        start_ok_next      = start_ok_reg;
        middle_ok_next     = middle_ok_reg;
        voltage_raw_next   = voltage_raw_reg;
        current_raw_next   = current_raw_reg;
        energy_raw_next    = energy_raw_reg;
        res_valid_next     = res_valid_reg && !res_ready;
        res_data_next      = res_data_reg;

        if (accept) begin
            if (frame_end) begin
                // fields needed by a passing frame were all captured earlier
                res_valid_next        = 1'b1;
                res_data_next.status      = status;
                res_data_next.address     = address_reg;
                res_data_next.voltage_raw = voltage_raw_reg;
                res_data_next.current_raw = current_raw_reg;
                res_data_next.energy_raw  = energy_raw_reg;

                byte_index_next    = '0;
                running_sum_next   = '0;
                previous_byte_next = '0;
                address_next       = '0;
                length_next        = '0;
                start_ok_next      = 1'b0;
                middle_ok_next     = 1'b0;
                voltage_raw_next   = '0;
                current_raw_next   = '0;
                energy_raw_next    = '0;
            end else begin
                if (byte_index_reg == POS_HEAD) begin
                    start_ok_next = (frame_byte == HEAD_MARK);
                end
                if (byte_index_reg == POS_MIDDLE) begin
                    middle_ok_next = (frame_byte == HEAD_MARK);
                end
                if (byte_index_reg == POS_LENGTH) begin
                    length_next = frame_byte;
                end
                for (int i = 0; i < ADDR_BYTES; i++) begin
                    if (byte_index_reg == INDEX_W'(i + 1)) begin
                        address_next[8*i +: 8] = frame_byte;
                    end
                end
                if (byte_index_reg == POS_VOLT_LO) voltage_raw_next[7:0]  = plain;
                if (byte_index_reg == POS_VOLT_HI) voltage_raw_next[15:8] = plain;
                if (byte_index_reg == POS_CURR_LO) current_raw_next[7:0]  = plain;
                if (byte_index_reg == POS_CURR_HI) current_raw_next[15:8] = plain;
                if (byte_index_reg == POS_ENGY_LO) energy_raw_next[7:0]   = plain;
                if (byte_index_reg == POS_ENGY_HI) energy_raw_next[15:8]  = plain;

                // sum trails by one word so the checksum word stays out of it
                if (byte_index_reg != POS_HEAD) begin
                    running_sum_next = running_sum_reg + previous_byte_reg;
                end
                previous_byte_next = frame_byte;
                if (byte_index_reg != INDEX_MAX) begin
                    byte_index_next = byte_index_reg + INDEX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg    <= '0;
            running_sum_reg   <= '0;
            previous_byte_reg <= '0;
            address_reg       <= '0;
            length_reg        <= '0;
            start_ok_reg      <= 1'b0;
            middle_ok_reg     <= 1'b0;
            voltage_raw_reg   <= '0;
            current_raw_reg   <= '0;
            energy_raw_reg    <= '0;
            res_valid_reg     <= 1'b0;
        end else begin
            byte_index_reg    <= byte_index_next;
            running_sum_reg   <= running_sum_next;
            previous_byte_reg <= previous_byte_next;
            address_reg       <= address_next;
            length_reg        <= length_next;
            start_ok_reg      <= start_ok_next;
            middle_ok_reg     <= middle_ok_next;
            voltage_raw_reg   <= voltage_raw_next;
            current_raw_reg   <= current_raw_next;
            energy_raw_reg    <= energy_raw_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_data_reg <= res_data_next;
    end

endmodule

`default_nettype wire

[rtl/mfp_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfp_decode (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            res_valid,
    output logic                                 res_ready,
    input  wire mfp_pkg::frame_result_t          res_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [2:0]                           status,
    output logic [mfp_pkg::ADDR_W-1:0]           meter_address,
    output logic [mfp_pkg::READING_W-1:0]        voltage_tenths,
    output logic [mfp_pkg::READING_W-1:0]        current_hundredths,
    output logic [mfp_pkg::READING_W-1:0]        energy_hundredths
);
    import mfp_pkg::*;

    logic                 out_valid_reg;
    logic [2:0]           status_reg, status_next;
    logic [ADDR_W-1:0]    address_reg, address_next;
    logic [READING_W-1:0] voltage_reg, voltage_next;
    logic [READING_W-1:0] current_reg, current_next;
    logic [READING_W-1:0] energy_reg, energy_next;
    logic                 take;

    assign res_ready = !out_valid_reg || out_ready;
    assign take      = res_valid && res_ready;

    always_comb begin
        status_next = res_data.status;
        // failed frames report zeros
        if (res_data.status == ST_OK) begin
            address_next = res_data.address;
            voltage_next = bcd_pair(res_data.voltage_raw);
            current_next = bcd_pair(res_data.current_raw);
            energy_next  = bcd_pair(res_data.energy_raw);
        end else begin
            address_next = '0;
            voltage_next = '0;
            current_next = '0;
            energy_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg  <= status_next;
            address_reg <= address_next;
            voltage_reg <= voltage_next;
            current_reg <= current_next;
            energy_reg  <= energy_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign meter_address      = address_reg;
    assign voltage_tenths     = voltage_reg;
    assign current_hundredths = current_reg;
    assign energy_hundredths  = energy_reg;

endmodule

`default_nettype wire

[rtl/meter_frame_parser_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Meter frame parser: takes one frame word per cycle while s_ready is high,
// with s_frame_end on the last word, and, for each frame, returns one result
// with a status code (ok, short, delimiter, length, checksum, data short),
// the 48-bit meter address and three readings, BCD in the frame and returned
// as binary (0.1 V, 0.01 A, 0.01 kWh); address and readings are zero unless
// the status is ok. Words may follow back to back with no gap between frames.
// The frame tracker checks the last word in the cycle it is offered and
// registers the result at the edge that takes it; the decode stage converts
// the readings and registers them when it takes that result, which drives
// m_valid. Each stage holds its result while m_ready is low.
module meter_frame_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_frame_byte,
    input  wire logic        s_frame_end,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [47:0]      m_meter_address,
    output logic [14:0]      m_voltage_tenths,
    output logic [14:0]      m_current_hundredths,
    output logic [14:0]      m_energy_hundredths
);
    import mfp_pkg::*;

    logic          res_valid;
    logic          res_ready;
    frame_result_t res_data;

    mfp_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_byte (s_frame_byte),
        .frame_end  (s_frame_end),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    mfp_decode u_decode (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .res_data           (res_data),
        .out_valid          (m_valid),
        .out_ready          (m_ready),
        .status             (m_status),
        .meter_address      (m_meter_address),
        .voltage_tenths     (m_voltage_tenths),
        .current_hundredths (m_current_hundredths),
        .energy_hundredths  (m_energy_hundredths)
    );

endmodule

`default_nettype wire
